### hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

### hw/rtl/cda_pkg.sv
// Package for the calendar date advance block: types, field layout, month table.
// No dependencies.
`timescale 1ns / 1ps

package cda_pkg;

	localparam int unsigned DayW   = 6;
	localparam int unsigned MonthW = 4;
	localparam int unsigned YearW  = 16;
	localparam int unsigned CountW = 16;
	localparam int unsigned RdayW  = 5;

	localparam int unsigned InDataW  = 48;
	localparam int unsigned OutDataW = 32;

	// y / 400 approximated as (y * DivMul) >> DivShift; never above the true quotient
	localparam int unsigned DivMul   = 5242;
	localparam int unsigned DivShift = 21;
	localparam int unsigned QuotW    = 8;
	localparam int unsigned RemW     = 9;

	localparam logic [MonthW-1:0] MonthJan = 4'd1;
	localparam logic [MonthW-1:0] MonthFeb = 4'd2;
	localparam logic [MonthW-1:0] MonthDec = 4'd12;

	localparam logic [YearW-1:0] YearMax = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CLAMP,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rem;
		logic clamp;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
	} status_t;

	function automatic logic [RdayW-1:0] month_days(input logic [MonthW-1:0] m,
		input logic leap);
		logic [RdayW-1:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = leap ? 5'd29 : 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### hw/rtl/cda_ctrl.sv
// Sequencer for the date advance: load, year split, clamp, day stepping, hand-off.
// Depends on cda_pkg.
`timescale 1ns / 1ps

module cda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output cda_pkg::cmd_t     cmd,
	input  cda_pkg::status_t  status
);

	cda_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		cmd       = '0;
		case (state_q)
			cda_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = cda_pkg::ST_DIV;
				end
			end
			cda_pkg::ST_DIV: begin
				cmd.rem = 1'b1;
				state_d = cda_pkg::ST_CLAMP;
			end
			cda_pkg::ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = cda_pkg::ST_RUN;
			end
			cda_pkg::ST_RUN: begin
				if (status.count_zero) begin
					state_d = cda_pkg::ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			cda_pkg::ST_DONE: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = cda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cda_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/cda_datapath.sv
// Date registers, year-mod-400 tracking and the one-day step.
// Depends on cda_pkg.
`timescale 1ns / 1ps

module cda_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cda_pkg::cmd_t                  cmd,
	output cda_pkg::status_t               status,
	input  logic [cda_pkg::InDataW-1:0]    in_data,   // day, month, year, count
	output logic [cda_pkg::OutDataW-1:0]   out_data   // day, month, year, overflow
);

	localparam int unsigned ProdW = cda_pkg::YearW + 13;

	logic [cda_pkg::DayW-1:0]   day_q;
	logic [cda_pkg::MonthW-1:0] month_q;
	logic [cda_pkg::YearW-1:0]  year_q;
	logic [cda_pkg::CountW-1:0] count_q;
	logic [cda_pkg::QuotW-1:0]  quot_q;
	logic [cda_pkg::RemW-1:0]   rem_q;
	logic                       ovf_q;

	logic [cda_pkg::DayW-1:0]   in_day;
	logic [cda_pkg::MonthW-1:0] in_month, month_clamped;
	logic [cda_pkg::YearW-1:0]  in_year;
	logic [cda_pkg::CountW-1:0] in_count;
	logic [ProdW-1:0]           div_prod;
	logic [cda_pkg::YearW-1:0]  quot_x400, rem_raw, rem_fix;
	logic                       leap;
	logic [cda_pkg::RdayW-1:0]  mdays;

	assign in_day   = in_data[5:0];
	assign in_month = in_data[9:6];
	assign in_year  = in_data[25:10];
	assign in_count = in_data[41:26];

	always_comb begin
		if (in_month == '0) begin
			month_clamped = cda_pkg::MonthJan;
		end else if (in_month > cda_pkg::MonthDec) begin
			month_clamped = cda_pkg::MonthDec;
		end else begin
			month_clamped = in_month;
		end
	end

	assign div_prod = ProdW'(in_year) * ProdW'(cda_pkg::DivMul);

	// quotient may be one short, so the remainder stays below 800
	assign quot_x400 = cda_pkg::YearW'(quot_q) * cda_pkg::YearW'(400);
	assign rem_raw   = year_q - quot_x400;
	assign rem_fix   = (rem_raw >= cda_pkg::YearW'(400)) ? rem_raw - cda_pkg::YearW'(400)
		: rem_raw;

	// leap from year mod 400: divisible by 4, and not a non-zero century
	assign leap = (rem_q[1:0] == 2'b00) && (rem_q != 9'd100) && (rem_q != 9'd200)
		&& (rem_q != 9'd300);
	assign mdays = cda_pkg::month_days(month_q, leap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= in_count;
				ovf_q   <= 1'b0;
			end else if (cmd.step) begin
				count_q <= count_q - 1'b1;
				if (day_q >= cda_pkg::DayW'(mdays) && month_q == cda_pkg::MonthDec
					&& year_q == cda_pkg::YearMax) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= in_day;
			month_q <= month_clamped;
			year_q  <= in_year;
			quot_q  <= div_prod[cda_pkg::DivShift +: cda_pkg::QuotW];
		end else if (cmd.rem) begin
			rem_q <= rem_fix[cda_pkg::RemW-1:0];
		end else if (cmd.clamp) begin
			if (day_q == '0) begin
				day_q <= cda_pkg::DayW'(1);
			end else if (day_q > cda_pkg::DayW'(mdays)) begin
				day_q <= cda_pkg::DayW'(mdays);
			end
		end else if (cmd.step) begin
			if (day_q >= cda_pkg::DayW'(mdays)) begin
				day_q <= cda_pkg::DayW'(1);
				if (month_q == cda_pkg::MonthDec) begin
					month_q <= cda_pkg::MonthJan;
					year_q  <= year_q + 1'b1;
					// 65535 mod 400 is 335, so the wrap to year 0 resets it too
					if (rem_q == 9'd399 || year_q == cda_pkg::YearMax) begin
						rem_q <= '0;
					end else begin
						rem_q <= rem_q + 1'b1;
					end
				end else begin
					month_q <= month_q + 1'b1;
				end
			end else begin
				day_q <= day_q + 1'b1;
			end
		end
	end

	assign status.count_zero = (count_q == '0);

	assign out_data = {6'd0, ovf_q, year_q, month_q, day_q[cda_pkg::RdayW-1:0]};

endmodule

### hw/rtl/calendar_date_advance.sv
// Top level of the calendar date advance block.
// Depends on cda_pkg, cda_ctrl and cda_datapath.
//
// Takes a start date and a day count, clamps the date into range and steps it forward
// one day per clock with Gregorian leap rules. One item is worked at a time: an item
// goes through set-up (load, year-mod-400 split, clamp), then day_count steps of the
// single-day step unit, then a check that sees the count run out, then the result is
// held until taken before the next item is accepted. No reset sweep is needed.
`timescale 1ns / 1ps

module calendar_date_advance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [5:0] start_day, [9:6] start_month, [25:10] start_year, [41:26] day_count
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [4:0] result_day, [8:5] result_month, [24:9] result_year, [25] year_overflow
	output logic [31:0] m_tdata
);

	cda_pkg::cmd_t    cmd;
	cda_pkg::status_t status;

	cda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	cda_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (s_tdata),
		.out_data (m_tdata)
	);

endmodule

### hw/rtl/cda_checker.sv
// Port-level checks for calendar_date_advance, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cda_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [47:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// result is held while stalled
	`ASSERT_PROP(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
	// only one item in flight: never ready for input while a result is shown
	`ASSERT_NEVER(a_one_item, clk, arst_n, s_tready && m_tvalid)
	// an accepted item closes the input until its result is taken
	`ASSERT_PROP(a_busy_after, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)
	// result date is in range
	`ASSERT_PROP(a_date_range, clk, arst_n, m_tvalid |-> (m_tdata[4:0] != 5'd0 && m_tdata[8:5] != 4'd0 && m_tdata[8:5] <= 4'd12))
	// spare bits of the output word stay zero
	`ASSERT_PROP(a_pad_zero, clk, arst_n, m_tvalid |-> (m_tdata[31:26] == 6'd0))

endmodule

bind calendar_date_advance cda_checker u_cda_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
